// File: design/dds_pkg.sv
// Shared types, codes and constants for the DFA dead state finder.
package dds_pkg;

    localparam int STATE_W       = 7;
    localparam int DEF_MAX_NODES = 64;

    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_ATTR = 2'd1;
    localparam logic [1:0] REQ_RUN  = 2'd2;

    localparam logic [1:0] ATTR_NORMAL = 2'd0;
    localparam logic [1:0] ATTR_ACCEPT = 2'd1;
    localparam logic [1:0] ATTR_DEAD   = 2'd2;

    localparam logic [STATE_W-1:0] REG_STATE_COUNT_RST = 7'd64;
    localparam logic [STATE_W-1:0] REG_START_STATE_RST = 7'd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [STATE_W-1:0] src_state;
        logic [STATE_W-1:0] dest_state;
        logic [1:0]         attribute;
    } cmd_t;

    typedef struct packed {
        logic [STATE_W-1:0] state_index;
        logic               dead;
        logic               last;
    } res_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               wr_edge;
        logic               wr_attr;
        logic [STATE_W-1:0] src_idx;
        logic [STATE_W-1:0] dst_idx;
        logic [1:0]         attr;
        logic               prep;
        logic               launch;
        logic               probe;
        logic [STATE_W-1:0] launch_idx;
        logic               capture;
        logic               shift;
    } ctl_t;

endpackage

// File: design/dds_cell.sv
// One state's cell: matrix row, attribute, reach and dead flags, ring bus stage.
module dds_cell
    import dds_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int INDEX     = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_t                 ctl,
    input  logic [MAX_NODES-1:0] mask,
    input  logic [MAX_NODES-1:0] accept_vec,
    input  logic                 bus_vld_in,
    input  logic                 bus_probe_in,
    input  logic [STATE_W-1:0]   bus_org_in,
    input  logic [MAX_NODES-1:0] bus_row_in,
    input  logic                 dead_in,
    output logic                 bus_vld_out,
    output logic                 bus_probe_out,
    output logic [STATE_W-1:0]   bus_org_out,
    output logic [MAX_NODES-1:0] bus_row_out,
    output logic                 dead_out,
    output logic                 accept
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [STATE_W-1:0]   ME   = STATE_W'(INDEX);
    localparam logic [MAX_NODES-1:0] SELF = MAX_NODES'(1) << INDEX;

    logic [MAX_NODES-1:0] row_reg, row_next;
    logic [1:0]           attr_reg, attr_next;
    logic                 reach_reg, reach_next;
    logic                 dead_reg, dead_next;
    logic                 bus_vld_reg, bus_vld_next;
    logic                 bus_probe_reg, bus_probe_next;
    logic [STATE_W-1:0]   bus_org_reg, bus_org_next;
    logic [MAX_NODES-1:0] bus_row_reg, bus_row_next;

    always_comb
    begin
        row_next       = row_reg;
        attr_next      = attr_reg;
        reach_next     = reach_reg;
        dead_next      = dead_reg;
        bus_vld_next   = 1'b0;
        bus_probe_next = bus_probe_in;
        bus_org_next   = bus_org_in;
        bus_row_next   = bus_row_in;

        if (ctl.wr_edge && ctl.src_idx == ME)
        begin
            for (int j = 0; j < MAX_NODES; j++)
            begin
                if (ctl.dst_idx == STATE_W'(j))
                begin
                    row_next[j] = 1'b1;
                end
            end
        end

        if (ctl.wr_attr && ctl.src_idx == ME)
        begin
            attr_next = ctl.attr;
        end

        // Drop edges past the state count, add the self loop.
        if (ctl.prep)
        begin
            row_next   = (row_reg & mask) | SELF;
            reach_next = 1'b0;
        end

        // Passing row: pivot merged if reached, probe sets reach; then forwarded.
        if (bus_vld_in)
        begin
            if (!bus_probe_in)
            begin
                if (row_reg[bus_org_in[IDX_W-1:0]])
                begin
                    row_next = row_reg | bus_row_in;
                end
            end
            else
            begin
                reach_next = bus_row_in[INDEX];
            end
            if (bus_org_in != ME)
            begin
                bus_vld_next = 1'b1;
            end
        end

        if (ctl.launch && ctl.launch_idx == ME)
        begin
            bus_vld_next   = 1'b1;
            bus_probe_next = ctl.probe;
            bus_org_next   = ME;
            bus_row_next   = row_reg;
            if (ctl.probe)
            begin
                reach_next = 1'b1;
            end
        end

        if (ctl.capture)
        begin
            dead_next = !reach_reg || (attr_reg == ATTR_DEAD) ||
                        ((attr_reg != ATTR_ACCEPT) && ((row_reg & accept_vec) == '0));
            row_next  = '0;
            attr_next = ATTR_NORMAL;
        end

        if (ctl.shift)
        begin
            dead_next = dead_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            attr_reg    <= ATTR_NORMAL;
            reach_reg   <= 1'b0;
            dead_reg    <= 1'b0;
            bus_vld_reg <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            attr_reg    <= attr_next;
            reach_reg   <= reach_next;
            dead_reg    <= dead_next;
            bus_vld_reg <= bus_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bus_probe_reg <= bus_probe_next;
        bus_org_reg   <= bus_org_next;
        bus_row_reg   <= bus_row_next;
    end

    assign bus_vld_out   = bus_vld_reg;
    assign bus_probe_out = bus_probe_reg;
    assign bus_org_out   = bus_org_reg;
    assign bus_row_out   = bus_row_reg;
    assign dead_out      = dead_reg;
    assign accept        = (attr_reg == ATTR_ACCEPT);

endmodule

// File: design/dds_ctrl.sv
// Sequencer: command decode, closure schedule, probe, result emission.
module dds_ctrl
    import dds_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cmd_t               cmd,
    input  logic [STATE_W-1:0] n_eff,
    input  logic [STATE_W-1:0] start_state,
    input  logic               dead_head,
    output logic               busy,
    output ctl_t               ctl,
    output res_t               result,
    output logic               result_strobe
);

    localparam int CNT_W = $clog2(3 * MAX_NODES);
    localparam logic [STATE_W-1:0] MAX_N = STATE_W'(MAX_NODES);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_CLOSE = 6'b000100,
        ST_PROBE = 6'b001000,
        ST_CAPT  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STATE_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]   close_end;
    logic [CNT_W-2:0]   half;
    logic               src_ok, dst_ok, start_ok, is_last;

    assign close_end = CNT_W'(n_eff) + CNT_W'(n_eff) + CNT_W'(MAX_NODES - 2);
    assign half      = cnt_reg[CNT_W-1:1];
    assign src_ok    = (cmd.src_state != '0) && (cmd.src_state <= MAX_N);
    assign dst_ok    = (cmd.dest_state != '0) && (cmd.dest_state <= MAX_N);
    assign start_ok  = (start_state != '0) && (start_state <= n_eff);
    assign is_last   = (idx_reg == n_eff);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        ctl.src_idx = cmd.src_state - STATE_W'(1);
        ctl.dst_idx = cmd.dest_state - STATE_W'(1);
        ctl.attr    = cmd.attribute;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.req_type)
                        REQ_EDGE: ctl.wr_edge = src_ok && dst_ok;
                        REQ_ATTR: ctl.wr_attr = src_ok;
                        REQ_RUN:  state_next  = ST_PREP;
                        default:  ;
                    endcase
                end
            end
            ST_PREP:
            begin
                ctl.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                // Launch pivot k on even counts; the last one needs a full lap.
                ctl.launch     = !cnt_reg[0] && (STATE_W'(half) < n_eff);
                ctl.launch_idx = STATE_W'(half);
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == close_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                ctl.launch     = (cnt_reg == '0) && start_ok;
                ctl.probe      = 1'b1;
                ctl.launch_idx = start_state - STATE_W'(1);
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_NODES))
                begin
                    state_next = ST_CAPT;
                end
            end
            ST_CAPT:
            begin
                ctl.capture = 1'b1;
                idx_next    = STATE_W'(1);
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                ctl.shift = 1'b1;
                idx_next  = idx_reg + STATE_W'(1);
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy               = (state_reg != ST_IDLE);
    assign result_strobe      = (state_reg == ST_EMIT);
    assign result.state_index = idx_reg;
    assign result.dead        = dead_head;
    assign result.last        = is_last;

endmodule

// File: design/dds_apb_regs.sv
// APB configuration registers: state count and start state.
module dds_apb_regs
    import dds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [STATE_W-1:0] state_count,
    output logic [STATE_W-1:0] start_state
);

    logic [STATE_W-1:0] count_reg, count_next;
    logic [STATE_W-1:0] start_reg, start_next;
    logic               wr;

    assign wr = psel && penable && pwrite;

    always_comb
    begin
        count_next = count_reg;
        start_next = start_reg;
        if (wr && !paddr[2])
        begin
            count_next = pwdata[STATE_W-1:0];
        end
        if (wr && paddr[2])
        begin
            start_next = pwdata[STATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= REG_STATE_COUNT_RST;
            start_reg <= REG_START_STATE_RST;
        end
        else
        begin
            count_reg <= count_next;
            start_reg <= start_next;
        end
    end

    assign prdata      = {{(32 - STATE_W){1'b0}}, (paddr[2] ? start_reg : count_reg)};
    assign pready      = 1'b1;
    assign state_count = count_reg;
    assign start_state = start_reg;

endmodule

// File: design/dfa_dead_state_finder_top.sv
// Top level of the DFA dead state finder: registers, sequencer and ring of cells.
//
//  channel   handshake              word
//  -------   ---------------------  -------------------------------------------
//  command   start & !busy          cmd: req_type, src_state, dest_state, attribute
//  result    result_strobe          result: state_index, dead, last
//  config    psel & penable & pwrite  paddr 0 state_count, paddr 4 start_state
//
// Edge and attribute words are applied in the idle state and do not raise busy; a run keeps
// busy high (n = effective state count) through prep, the pivot rows circling the ring of cells,
// the start-row probe and capture, then n result words, one word per cycle.
// Reset clears the matrix and attributes in the cells at once; no clearing pass.
// The receiver cannot stall: each result stands for exactly one cycle.
module dfa_dead_state_finder_top
    import dds_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    output res_t        result,
    output logic        result_strobe,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [STATE_W-1:0] MAX_N = STATE_W'(MAX_NODES);

    logic [STATE_W-1:0]   state_count, start_state, n_eff;
    logic [MAX_NODES-1:0] mask, accept_vec, dead_vec;
    logic [MAX_NODES-1:0] bus_vld, bus_probe;
    logic [STATE_W-1:0]   bus_org [MAX_NODES];
    logic [MAX_NODES-1:0] bus_row [MAX_NODES];
    ctl_t                 ctl;

    dds_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .state_count (state_count),
        .start_state (start_state)
    );

    // Clamp the state count to 1..MAX_NODES.
    always_comb
    begin
        if (state_count == '0)
        begin
            n_eff = STATE_W'(1);
        end
        else if (state_count > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = state_count;
        end
        for (int j = 0; j < MAX_NODES; j++)
        begin
            mask[j] = (STATE_W'(j) < n_eff);
        end
    end

    dds_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .n_eff         (n_eff),
        .start_state   (start_state),
        .dead_head     (dead_vec[0]),
        .busy          (busy),
        .ctl           (ctl),
        .result        (result),
        .result_strobe (result_strobe)
    );

    for (genvar i = 0; i < MAX_NODES; i++)
    begin : g_cell
        localparam int PREV = (i + MAX_NODES - 1) % MAX_NODES;
        logic dead_in;

        if (i == MAX_NODES - 1)
        begin : g_tail
            assign dead_in = 1'b0;
        end
        else
        begin : g_body
            assign dead_in = dead_vec[i + 1];
        end

        dds_cell #(
            .MAX_NODES (MAX_NODES),
            .INDEX     (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .mask          (mask),
            .accept_vec    (accept_vec),
            .bus_vld_in    (bus_vld[PREV]),
            .bus_probe_in  (bus_probe[PREV]),
            .bus_org_in    (bus_org[PREV]),
            .bus_row_in    (bus_row[PREV]),
            .dead_in       (dead_in),
            .bus_vld_out   (bus_vld[i]),
            .bus_probe_out (bus_probe[i]),
            .bus_org_out   (bus_org[i]),
            .bus_row_out   (bus_row[i]),
            .dead_out      (dead_vec[i]),
            .accept        (accept_vec[i])
        );
    end

endmodule

// File: sim/tb_dfa_dead_state_finder_top.sv
// Testbench for the DFA dead state finder: directed and random automata checked against a predictor.
module tb_dfa_dead_state_finder_top;
    import dds_pkg::*;

    localparam int NODES        = DEF_MAX_NODES;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RUN_TAIL     = 5 * NODES + 8;
    localparam int RANDOM_ITEMS = 350;

    localparam logic [2:0] ADDR_STATE_COUNT = 3'd0;
    localparam logic [2:0] ADDR_START_STATE = 3'd4;
    localparam logic [1:0] REQ_SPARE        = 2'd3;
    localparam logic [1:0] ATTR_SPARE       = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    cmd_t        cmd;
    logic        busy;
    res_t        result;
    logic        result_strobe;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the automaton and registers
    logic [NODES-1:0]   edge_rows [NODES];
    logic [1:0]         node_attr [NODES];
    logic [STATE_W-1:0] cfg_count;
    logic [STATE_W-1:0] cfg_start;
    res_t               pending_verdicts [$];

    int     fault_count;
    int     item_count;
    longint cycle_count;

    dfa_dead_state_finder_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .busy          (busy),
        .result        (result),
        .result_strobe (result_strobe),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic cmd_t make_cmd(input logic [1:0] req, input logic [6:0] src,
                                      input logic [6:0] dst, input logic [1:0] attr);
        cmd_t c;
        c.req_type   = req;
        c.src_state  = src;
        c.dest_state = dst;
        c.attribute  = attr;
        return c;
    endfunction

    function automatic cmd_t noise_cmd();
        return make_cmd(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                        7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int eff_count();
        if (cfg_count < 1)
            return 1;
        if (cfg_count > NODES)
            return NODES;
        return cfg_count;
    endfunction

    // Close reachability, queue one verdict per state, then clear the automaton.
    function automatic void scan_dead_states();
        logic [NODES-1:0] m [NODES];
        logic [NODES-1:0] mask;
        logic [NODES-1:0] accept_set;
        logic [NODES-1:0] from_start;
        res_t             v;
        int               n;
        n = eff_count();
        mask = (n == NODES) ? {NODES{1'b1}} : ((64'd1 << n) - 64'd1);
        accept_set = '0;
        from_start = '0;
        for (int i = 0; i < n; i++)
        begin
            m[i] = (edge_rows[i] & mask) | (64'd1 << i);
            if (node_attr[i] == ATTR_ACCEPT)
                accept_set[i] = 1'b1;
        end
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                if (m[i][k])
                    m[i] = m[i] | m[k];
        if (cfg_start >= 1 && cfg_start <= n)
            from_start = m[cfg_start - 1];
        for (int i = 0; i < n; i++)
        begin
            v.state_index = 7'(i + 1);
            if (!from_start[i])
                v.dead = 1'b1;
            else if (node_attr[i] == ATTR_DEAD)
                v.dead = 1'b1;
            else if (node_attr[i] == ATTR_ACCEPT)
                v.dead = 1'b0;
            else
                v.dead = ((m[i] & accept_set) == '0);
            v.last = (i + 1 == n);
            pending_verdicts.push_back(v);
        end
        for (int i = 0; i < NODES; i++)
        begin
            edge_rows[i] = '0;
            node_attr[i] = ATTR_NORMAL;
        end
    endfunction

    function automatic void apply_command(input cmd_t c);
        case (c.req_type)
            REQ_EDGE:
                if (c.src_state >= 1 && c.src_state <= NODES &&
                    c.dest_state >= 1 && c.dest_state <= NODES)
                    edge_rows[c.src_state - 1][c.dest_state - 1] = 1'b1;
            REQ_ATTR:
                if (c.src_state >= 1 && c.src_state <= NODES)
                    node_attr[c.src_state - 1] = c.attribute;
            REQ_RUN:
                scan_dead_states();
            default:
                ;
        endcase
    endfunction

    // Leaves start high on return; the next call or release_port takes it over.
    task automatic send_word(input cmd_t c, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd   <= noise_cmd();
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_command(c);
        if (c.req_type != REQ_SPARE)
            item_count++;
    endtask

    task automatic release_port();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        release_port();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [6:0] value,
                             input logic [24:0] upper);
        logic [31:0] rd;
        wait_drained();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {upper, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_STATE_COUNT)
            cfg_count = value;
        else
            cfg_start = value;
        // read back through the same port
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[6:0] !== value)
            note_fault($sformatf("register 0x%0h read back: expected %0d, got %0d",
                                 addr, value, rd[6:0]));
    endtask

    task automatic test_chain();
        write_reg(ADDR_STATE_COUNT, 7'd4, '0);
        write_reg(ADDR_START_STATE, 7'd1, '0);
        send_word(make_cmd(REQ_EDGE, 7'd1, 7'd2, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd2, 7'd3, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd3, 7'd4, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_ATTR, 7'd4, 7'd0, ATTR_ACCEPT), pick_gap());
        send_word(make_cmd(REQ_RUN, 7'd0, 7'd0, ATTR_NORMAL), pick_gap());
    endtask

    task automatic test_attributes();
        write_reg(ADDR_STATE_COUNT, 7'd5, '0);
        write_reg(ADDR_START_STATE, 7'd2, '0);
        send_word(make_cmd(REQ_EDGE, 7'd2, 7'd3, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd3, 7'd4, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd2, 7'd5, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_ATTR, 7'd3, 7'd0, ATTR_DEAD), pick_gap());
        send_word(make_cmd(REQ_ATTR, 7'd4, 7'd0, ATTR_ACCEPT), pick_gap());
        send_word(make_cmd(REQ_ATTR, 7'd5, 7'd0, ATTR_SPARE), pick_gap());
        send_word(make_cmd(REQ_RUN, 7'd127, 7'd127, ATTR_SPARE), pick_gap());
    endtask

    task automatic test_out_of_range();
        // count above the node limit clamps to the full size
        write_reg(ADDR_STATE_COUNT, 7'd127, '0);
        write_reg(ADDR_START_STATE, 7'd64, '0);
        send_word(make_cmd(REQ_EDGE, 7'd0, 7'd5, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd65, 7'd1, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd127, 7'd127, ATTR_SPARE), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd10, 7'd0, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd10, 7'd65, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_SPARE, 7'd127, 7'd127, ATTR_SPARE), pick_gap());
        send_word(make_cmd(REQ_ATTR, 7'd0, 7'd0, ATTR_ACCEPT), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd64, 7'd64, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_ATTR, 7'd64, 7'd0, ATTR_ACCEPT), pick_gap());
        send_word(make_cmd(REQ_RUN, 7'd0, 7'd0, ATTR_NORMAL), pick_gap());
    endtask

    task automatic test_count_limits();
        // zero count acts as one state
        write_reg(ADDR_STATE_COUNT, 7'd0, '0);
        write_reg(ADDR_START_STATE, 7'd1, '0);
        send_word(make_cmd(REQ_ATTR, 7'd1, 7'd0, ATTR_ACCEPT), pick_gap());
        send_word(make_cmd(REQ_RUN, 7'd0, 7'd0, ATTR_NORMAL), pick_gap());
        // edge past the count, start state zero
        write_reg(ADDR_STATE_COUNT, 7'd3, '0);
        write_reg(ADDR_START_STATE, 7'd0, '0);
        send_word(make_cmd(REQ_EDGE, 7'd1, 7'd2, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_EDGE, 7'd2, 7'd10, ATTR_NORMAL), pick_gap());
        send_word(make_cmd(REQ_RUN, 7'd0, 7'd0, ATTR_NORMAL), pick_gap());
        // start state above the count
        write_reg(ADDR_START_STATE, 7'd127, '0);
        send_word(make_cmd(REQ_RUN, 7'd0, 7'd0, ATTR_NORMAL), pick_gap());
    endtask

    task automatic test_random_automata();
        int target;
        int n;
        int ops;
        int r;
        bit steady;
        logic [1:0] attr;
        target = item_count + RANDOM_ITEMS;
        while (item_count < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    n = $urandom_range(2, 10);
                else if (r < 90)
                    n = $urandom_range(11, 40);
                else
                    n = NODES;
                write_reg(ADDR_STATE_COUNT,
                          (n == NODES && $urandom_range(0, 1)) ? 7'($urandom_range(65, 127))
                                                                : 7'(n),
                          25'($urandom));
                n = eff_count();
                r = $urandom_range(0, 9);
                write_reg(ADDR_START_STATE,
                          (r == 0) ? 7'd0 :
                          (r == 1) ? 7'($urandom_range(n + 1, 127)) :
                                     7'($urandom_range(1, n)),
                          25'($urandom));
            end
            n = eff_count();
            steady = ($urandom_range(0, 3) == 0);
            ops = $urandom_range(2, (2 * n + 4 > 28) ? 28 : 2 * n + 4);
            repeat (ops)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_word(noise_cmd(), steady ? 0 : pick_gap());
                else if (r < 70)
                    send_word(make_cmd(REQ_EDGE, 7'($urandom_range(1, n)),
                                       7'($urandom_range(1, n)), 2'($urandom_range(0, 3))),
                              steady ? 0 : pick_gap());
                else
                begin
                    r = $urandom_range(0, 99);
                    attr = (r < 50) ? ATTR_ACCEPT : (r < 75) ? ATTR_DEAD :
                           (r < 88) ? ATTR_NORMAL : ATTR_SPARE;
                    send_word(make_cmd(REQ_ATTR, 7'($urandom_range(1, n)),
                                       7'($urandom_range(0, 127)), attr),
                              steady ? 0 : pick_gap());
                end
            end
            // now and then leave the loads pending into the next automaton
            if ($urandom_range(0, 9) != 0)
                send_word(make_cmd(REQ_RUN, 7'($urandom_range(0, 127)),
                                   7'($urandom_range(0, 127)), 2'($urandom_range(0, 3))),
                          steady ? 0 : pick_gap());
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
    endtask

    always @(posedge clk)
    begin : check_verdicts
        res_t want;
        if (rst_n && result_strobe)
        begin
            if (pending_verdicts.size() == 0)
                note_fault($sformatf("unexpected word: state %0d dead %0b last %0b",
                                     result.state_index, result.dead, result.last));
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.state_index !== want.state_index || result.dead !== want.dead ||
                    result.last !== want.last)
                    note_fault($sformatf(
                        "expected state %0d dead %0b last %0b, got state %0d dead %0b last %0b",
                        want.state_index, want.dead, want.last,
                        result.state_index, result.dead, result.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_dfa_dead_state_finder_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        fault_count = 0;
        item_count  = 0;
        cycle_count = 0;
        cfg_count   = REG_STATE_COUNT_RST;
        cfg_start   = REG_START_STATE_RST;
        for (int i = 0; i < NODES; i++)
        begin
            edge_rows[i] = '0;
            node_attr[i] = ATTR_NORMAL;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_chain();
        test_attributes();
        test_out_of_range();
        test_count_limits();
        test_random_automata();

        release_port();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (RUN_TAIL) @(posedge clk);
        if (fault_count == 0 && pending_verdicts.size() == 0)
            $display("tb_dfa_dead_state_finder_top: done, clean");
        else
            $display("tb_dfa_dead_state_finder_top: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
design/dds_pkg.sv
design/dds_cell.sv
design/dds_ctrl.sv
design/dds_apb_regs.sv
design/dfa_dead_state_finder_top.sv
sim/tb_dfa_dead_state_finder_top.sv
